// ===== rtl/bsoc_pkg.sv =====
// shared types and constant tables of the battery state-of-charge lookup
package bsoc_pkg;

	localparam int unsigned POINTS   = 18;
	localparam int unsigned SEGS     = POINTS - 1;
	localparam int unsigned IDX_W    = 5;
	localparam int unsigned MV_W     = 16;
	localparam int unsigned CNT_W    = 4;
	localparam int unsigned RECIP_W  = 21;
	localparam int unsigned RECIP_SH = 20;
	localparam int unsigned OFS_W    = 7;
	localparam int unsigned COEF_W   = 20;
	localparam int unsigned COEF_SH  = 14;
	localparam int unsigned PCT_W    = 7;
	localparam int unsigned FINE_W   = 15;

	localparam logic [FINE_W-1:0] FINE_FULL = 15'd25600;
	localparam logic [FINE_W-1:0] FINE_HALF = 15'd128;
	localparam logic [PCT_W-1:0]  PCT_MAX   = 7'd100;

	// open-circuit voltage breakpoints in mV
	localparam logic [12:0] OCV_MV [POINTS] = '{
		13'd3000, 13'd3100, 13'd3200, 13'd3300, 13'd3400,
		13'd3500, 13'd3600, 13'd3700, 13'd3750, 13'd3800,
		13'd3850, 13'd3900, 13'd3950, 13'd4000, 13'd4050,
		13'd4100, 13'd4150, 13'd4200
	};

	// charge at each breakpoint in whole percent
	localparam logic [PCT_W-1:0] OCV_PCT [POINTS] = '{
		7'd0,  7'd1,  7'd3,  7'd6,  7'd10,
		7'd15, 7'd22, 7'd32, 7'd40, 7'd52,
		7'd62, 7'd70, 7'd78, 7'd84, 7'd89,
		7'd93, 7'd97, 7'd100
	};

	// ceil(2^22 * rise / span) per segment: offset * coef >> 14 is the exact
	// truncated 1/256-percent slope term for offsets below the span
	localparam logic [COEF_W-1:0] SEG_COEF [SEGS] = '{
		20'd41944,  20'd83887,  20'd125830, 20'd167773, 20'd209716,
		20'd293602, 20'd419431, 20'd671089, 20'd1006633, 20'd838861,
		20'd671089, 20'd671089, 20'd503317, 20'd419431, 20'd335545,
		20'd335545, 20'd251659
	};

	// ceil(2^20 / count), a zero count acts as one; exact for 16-bit dividends
	localparam logic [RECIP_W-1:0] CELL_RECIP [16] = '{
		21'd1048576, 21'd1048576, 21'd524288, 21'd349526,
		21'd262144,  21'd209716,  21'd174763, 21'd149797,
		21'd131072,  21'd116509,  21'd104858, 21'd95326,
		21'd87382,   21'd80660,   21'd74899,  21'd69906
	};

	localparam logic [CNT_W-1:0] CELL_COUNT_RST = 4'd2;

	typedef struct packed {
		logic             zero;
		logic             full;
		logic [IDX_W-1:0] lo;
		logic [OFS_W-1:0] offset;
	} seg_t;

endpackage

// ===== rtl/bsoc_if.sv =====
// valid/ready channels for pack voltage samples and charge results
interface bsoc_in_if;
	logic        valid;
	logic        ready;
	logic [15:0] pack_mv;

	modport source (output valid, output pack_mv, input ready);
	modport sink (input valid, input pack_mv, output ready);
endinterface

interface bsoc_out_if;
	logic        valid;
	logic        ready;
	logic [14:0] soc_fine;
	logic [6:0]  soc_percent;

	modport source (output valid, output soc_fine, output soc_percent, input ready);
	modport sink (input valid, input soc_fine, input soc_percent, output ready);
endinterface

// ===== rtl/bsoc_seg_find.sv =====
// locates the table segment holding a cell voltage and the offset into it
module bsoc_seg_find (
	input  logic [bsoc_pkg::MV_W-1:0] cell_mv,
	output bsoc_pkg::seg_t            seg
);

	logic [bsoc_pkg::IDX_W-1:0] lo;
	logic [bsoc_pkg::MV_W-1:0]  diff;

	// last breakpoint at or below the voltage, inner points only
	always_comb begin
		lo = '0;
		for (int k = 1; k < bsoc_pkg::SEGS; k++) begin
			if (cell_mv >= bsoc_pkg::MV_W'(bsoc_pkg::OCV_MV[k]))
				lo = bsoc_pkg::IDX_W'(k);
		end
	end

	assign diff = cell_mv - bsoc_pkg::MV_W'(bsoc_pkg::OCV_MV[lo]);

	always_comb begin
		seg.zero   = cell_mv <= bsoc_pkg::MV_W'(bsoc_pkg::OCV_MV[0]);
		seg.full   = cell_mv >= bsoc_pkg::MV_W'(bsoc_pkg::OCV_MV[bsoc_pkg::POINTS-1]);
		seg.lo     = lo;
		seg.offset = diff[bsoc_pkg::OFS_W-1:0];
	end

endmodule

// ===== rtl/battery_soc_lookup.sv =====
// battery state of charge from pack voltage: four-stage interpolation pipeline
//
// sample carries the pack voltage in mV, result carries the charge in
// 1/256 percent and in whole percent (rounded half up), one result per
// sample in input order. cfg_we/cfg_wdata load the series cell count; write
// it only while the pipeline is empty. A count of zero acts as one.
// Throughput is one sample per cycle while the receiver is ready: stage 1
// divides by the cell count through a reciprocal multiply, stage 2 finds
// the table segment, stage 3 multiplies the offset by the segment slope,
// stage 4 adds the base charge and rounds. Each stage holds its own valid
// bit and moves on when the next stage is empty or moving, so a stalled
// receiver holds the result in place while upstream bubbles fill; nothing
// is dropped or repeated.
// Reset empties the pipeline and sets the cell count to two.
module battery_soc_lookup (
	input  logic                      clk,
	input  logic                      arst_n,
	bsoc_in_if.sink                   sample,
	bsoc_out_if.source                result,
	input  logic                      cfg_we,
	input  logic [bsoc_pkg::CNT_W-1:0] cfg_wdata
);

	logic [bsoc_pkg::RECIP_W-1:0] recip_q;

	logic                                         valid_s1, valid_s2, valid_s3, valid_s4;
	logic                                         en_s1, en_s2, en_s3, en_s4;
	logic [bsoc_pkg::MV_W-1:0]                    cell_s1;
	bsoc_pkg::seg_t                               seg_s2;
	logic                                         zero_s3, full_s3;
	logic [bsoc_pkg::PCT_W-1:0]                   base_s3;
	logic [bsoc_pkg::OFS_W+bsoc_pkg::COEF_W-1:0]  prod_s3;
	logic [bsoc_pkg::FINE_W-1:0]                  fine_s4;
	logic [bsoc_pkg::PCT_W-1:0]                   pct_s4;

	logic [bsoc_pkg::MV_W+bsoc_pkg::RECIP_W-1:0]  quot_full;
	bsoc_pkg::seg_t                               seg_c;
	logic [bsoc_pkg::FINE_W-1:0]                  fine_c;
	logic [bsoc_pkg::FINE_W:0]                    round_c;
	logic [bsoc_pkg::PCT_W-1:0]                   pct_c;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			recip_q <= bsoc_pkg::CELL_RECIP[bsoc_pkg::CELL_COUNT_RST];
		end else if (cfg_we) begin
			recip_q <= bsoc_pkg::CELL_RECIP[cfg_wdata];
		end
	end

	assign en_s4        = !valid_s4 || result.ready;
	assign en_s3        = !valid_s3 || en_s4;
	assign en_s2        = !valid_s2 || en_s3;
	assign en_s1        = !valid_s1 || en_s2;
	assign sample.ready = en_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
		end else begin
			if (en_s1) valid_s1 <= sample.valid;
			if (en_s2) valid_s2 <= valid_s1;
			if (en_s3) valid_s3 <= valid_s2;
			if (en_s4) valid_s4 <= valid_s3;
		end
	end

	// cell voltage = pack * ceil(2^20/count) >> 20
	assign quot_full = sample.pack_mv * recip_q;

	always_ff @(posedge clk) begin
		if (en_s1 && sample.valid) begin
			cell_s1 <= quot_full[bsoc_pkg::RECIP_SH +: bsoc_pkg::MV_W];
		end
	end

	bsoc_seg_find u_seg_find (
		.cell_mv (cell_s1),
		.seg     (seg_c)
	);

	always_ff @(posedge clk) begin
		if (en_s2 && valid_s1) begin
			seg_s2 <= seg_c;
		end
	end

	always_ff @(posedge clk) begin
		if (en_s3 && valid_s2) begin
			zero_s3 <= seg_s2.zero;
			full_s3 <= seg_s2.full;
			base_s3 <= bsoc_pkg::OCV_PCT[seg_s2.lo];
			prod_s3 <= seg_s2.offset * bsoc_pkg::SEG_COEF[seg_s2.lo];
		end
	end

	always_comb begin
		priority if (zero_s3) begin
			fine_c = '0;
		end else if (full_s3) begin
			fine_c = bsoc_pkg::FINE_FULL;
		end else begin
			fine_c = {base_s3, 8'd0}
				+ bsoc_pkg::FINE_W'(prod_s3[bsoc_pkg::OFS_W+bsoc_pkg::COEF_W-1:bsoc_pkg::COEF_SH]);
		end
		round_c = {1'b0, fine_c} + {1'b0, bsoc_pkg::FINE_HALF};
		pct_c   = (round_c[bsoc_pkg::FINE_W:8] > {1'b0, bsoc_pkg::PCT_MAX})
			? bsoc_pkg::PCT_MAX : round_c[8 +: bsoc_pkg::PCT_W];
	end

	always_ff @(posedge clk) begin
		if (en_s4 && valid_s3) begin
			fine_s4 <= fine_c;
			pct_s4  <= pct_c;
		end
	end

	assign result.valid       = valid_s4;
	assign result.soc_fine    = fine_s4;
	assign result.soc_percent = pct_s4;

endmodule

// ===== tb/tb_battery_soc_lookup.sv =====
// self-checking testbench for the battery state-of-charge lookup pipeline
module tb_battery_soc_lookup;

	localparam int unsigned CYCLE_LIMIT = 400000;
	localparam int unsigned BP_COUNT    = 18;
	localparam int unsigned HOLD_CYCLES = 120;

	typedef struct packed {
		logic [14:0] fine;
		logic [6:0]  pct;
	} charge_t;

	// open-circuit voltage breakpoints and their charge in whole percent
	localparam int unsigned BP_MV [BP_COUNT] = '{
		3000, 3100, 3200, 3300, 3400, 3500, 3600, 3700, 3750,
		3800, 3850, 3900, 3950, 4000, 4050, 4100, 4150, 4200
	};
	localparam int unsigned BP_PCT [BP_COUNT] = '{
		0, 1, 3, 6, 10, 15, 22, 32, 40,
		52, 62, 70, 78, 84, 89, 93, 97, 100
	};

	logic clk;
	logic arst_n;
	logic cfg_we;
	logic [bsoc_pkg::CNT_W-1:0] cfg_wdata;

	bsoc_in_if  smp();
	bsoc_out_if res();

	battery_soc_lookup dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.sample    (smp),
		.result    (res),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata)
	);

	logic [15:0] volt_q [$];
	charge_t     charge_q [$];
	logic [3:0]  cells_now = 4'd2;
	int unsigned err_cnt = 0;
	int unsigned cyc_cnt = 0;
	int unsigned tx_idle_pct = 0;
	int unsigned rx_idle_pct = 0;
	bit          in_took = 1'b0;
	bit          hold_req = 1'b0;
	bit          rx_hold = 1'b0;

	initial clk = 1'b0;
	always #4 clk = ~clk;

	function automatic charge_t charge_of_pack(logic [15:0] pack, logic [3:0] cells);
		int unsigned eff;
		int unsigned cell_mv;
		int unsigned lo;
		int unsigned fine;
		int unsigned pct;
		charge_t     c;
		eff = (cells == 4'd0) ? 1 : cells;
		cell_mv = pack / eff;
		lo = 0;
		if (cell_mv <= BP_MV[0]) begin
			fine = 0;
		end else if (cell_mv >= BP_MV[BP_COUNT-1]) begin
			fine = 25600;
		end else begin
			for (int k = 1; k < BP_COUNT - 1; k++) begin
				if (cell_mv >= BP_MV[k])
					lo = k;
			end
			fine = BP_PCT[lo] * 256
				+ ((cell_mv - BP_MV[lo]) * (BP_PCT[lo+1] - BP_PCT[lo]) * 256)
				/ (BP_MV[lo+1] - BP_MV[lo]);
		end
		pct = (fine + 128) / 256;
		if (pct > 100)
			pct = 100;
		c.fine = fine[14:0];
		c.pct = pct[6:0];
		return c;
	endfunction

	// mostly cell voltages around the table, some on breakpoints, some anywhere
	function automatic logic [15:0] pick_pack(logic [3:0] cells);
		int unsigned eff;
		int unsigned cell_mv;
		int unsigned pack;
		int unsigned r;
		eff = (cells == 4'd0) ? 1 : cells;
		r = $urandom_range(99);
		if (r < 15)
			return 16'($urandom);
		if (r < 35)
			cell_mv = BP_MV[$urandom_range(BP_COUNT - 1)] + $urandom_range(2) - 1;
		else
			cell_mv = $urandom_range(4260, 2940);
		pack = cell_mv * eff + $urandom_range(eff - 1);
		if (pack > 65535)
			pack = 65535;
		return pack[15:0];
	endfunction

	task automatic queue_random(int unsigned n);
		for (int i = 0; i < n; i++)
			volt_q.push_back(pick_pack(cells_now));
	endtask

	// sender pauses until every expected charge has come back
	task automatic drain();
		while (volt_q.size() != 0 || smp.valid || charge_q.size() != 0)
			@(posedge clk);
		repeat (6) @(posedge clk);
	endtask

	task automatic set_cells(logic [3:0] v);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_wdata <= v;
		cells_now = v;
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	// sender: hold the item until its transfer, then maybe idle
	always @(negedge clk) begin
		if (!arst_n) begin
			smp.valid <= 1'b0;
			smp.pack_mv <= '0;
		end else if (!smp.valid || in_took) begin
			if (volt_q.size() != 0 && $urandom_range(99) >= tx_idle_pct) begin
				smp.valid <= 1'b1;
				smp.pack_mv <= volt_q.pop_front();
			end else begin
				smp.valid <= 1'b0;
			end
		end
	end

	always @(negedge clk) begin
		res.ready <= arst_n && !rx_hold && ($urandom_range(99) >= rx_idle_pct);
	end

	// long receiver stall while the sender keeps offering samples
	initial begin
		wait (hold_req);
		@(posedge clk);
		rx_hold = 1'b1;
		repeat (HOLD_CYCLES) @(posedge clk);
		rx_hold = 1'b0;
	end

	always @(posedge clk) begin
		charge_t want;
		if (arst_n && res.valid && res.ready) begin
			if (charge_q.size() == 0) begin
				$display("%0t unexpected charge: got fine %0d pct %0d", $time,
					res.soc_fine, res.soc_percent);
				err_cnt++;
			end else begin
				want = charge_q.pop_front();
				if (res.soc_fine !== want.fine) begin
					$display("%0t soc_fine mismatch: expected %0d, got %0d", $time,
						want.fine, res.soc_fine);
					err_cnt++;
				end
				if (res.soc_percent !== want.pct) begin
					$display("%0t soc_percent mismatch: expected %0d, got %0d", $time,
						want.pct, res.soc_percent);
					err_cnt++;
				end
			end
		end
		in_took = arst_n && smp.valid && smp.ready;
		if (in_took)
			charge_q.push_back(charge_of_pack(smp.pack_mv, cells_now));
	end

	always @(posedge clk) cyc_cnt <= cyc_cnt + 1;

	initial begin
		wait (cyc_cnt == CYCLE_LIMIT);
		$display("[FAIL] regression broken");
		$finish;
	end

	initial begin
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_wdata = '0;
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// reset count of two: table edges, inner breakpoints, field extremes
		tx_idle_pct = 34;
		rx_idle_pct = 88;
		volt_q = '{16'd0, 16'd65535, 16'd6000, 16'd6001, 16'd6002, 16'd6200,
			16'd7400, 16'd7500, 16'd8399, 16'd8400, 16'd8401, 16'd7999};
		queue_random(80);
		drain();

		// zero count behaves as one
		set_cells(4'd0);
		volt_q = '{16'd3000, 16'd3001, 16'd4199, 16'd4200, 16'd65535, 16'd0, 16'd3750};
		queue_random(80);
		drain();

		// largest count: table edges and the top of the field
		set_cells(4'd15);
		volt_q = '{16'd45000, 16'd45015, 16'd62985, 16'd63000, 16'd65535};
		queue_random(80);
		drain();

		tx_idle_pct = 88;
		rx_idle_pct = 34;
		set_cells(4'd1);
		queue_random(120);
		drain();
		set_cells(4'd8);
		queue_random(120);
		drain();
		set_cells(4'd9);
		queue_random(100);
		drain();

		tx_idle_pct = 0;
		rx_idle_pct = 0;
		set_cells(4'd3);
		queue_random(120);
		hold_req = 1'b1;
		drain();
		set_cells(4'($urandom_range(15)));
		queue_random(120);
		drain();
		set_cells(4'd5);
		queue_random(100);
		drain();

		repeat (10) @(posedge clk);
		if (charge_q.size() != 0) begin
			$display("%0t %0d charge results never arrived, first expected fine %0d pct %0d",
				$time, charge_q.size(), charge_q[0].fine, charge_q[0].pct);
			err_cnt++;
		end
		if (err_cnt == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

endmodule

// ===== battery_soc_lookup.f =====
rtl/bsoc_pkg.sv
rtl/bsoc_if.sv
rtl/bsoc_seg_find.sv
rtl/battery_soc_lookup.sv
tb/tb_battery_soc_lookup.sv
